// ===== design/vlmrd_pkg.sv =====
// Package for the value list block: operation codes, data and count types,
// and the result record. Depends on nothing; every other design file imports it.
package vlmrd_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = 5;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_REPLACE = 2'd1,
      OP_COUNT   = 2'd2,
      OP_DELETE  = 2'd3
   } op_type;

   typedef struct packed {
      cnt_type match_count;
      cnt_type fill_count;
      logic    full_reject;
   } result_type;

endpackage

// ===== design/vlmrd_if.sv =====
// Handshake channels of the value list block: request and response.
// Depends on vlmrd_pkg for the payload types.
interface vlmrd_req_if;
   import vlmrd_pkg::*;

   logic     valid;
   logic     ready;
   op_type   op;
   data_type value;
   data_type new_value;

   modport source (output valid, output op, output value, output new_value, input ready);
   modport sink (input valid, input op, input value, input new_value, output ready);
endinterface

interface vlmrd_rsp_if;
   import vlmrd_pkg::*;

   logic    valid;
   logic    ready;
   cnt_type match_count;
   cnt_type fill_count;
   logic    full_reject;

   modport source (output valid, output match_count, output fill_count,
                   output full_reject, input ready);
   modport sink (input valid, input match_count, input fill_count,
                 input full_reject, output ready);
endinterface

// ===== design/vlmrd_mem.sv =====
// Entry storage of the value list: one write port and one registered read port.
// Depends on vlmrd_pkg for the data type.
module vlmrd_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  vlmrd_pkg::data_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output vlmrd_pkg::data_type rd_data
);
   import vlmrd_pkg::*;

   data_type mem [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/vlmrd_engine.sv =====
// Sequencer of the value list: takes requests, walks the entries one per
// cycle through a single comparator, and hands out one result. Uses vlmrd_pkg.
module vlmrd_engine #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int CW    = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   vlmrd_req_if.sink             req,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output vlmrd_pkg::data_type   mem_wr_data,
   output logic                  mem_rd_en,
   output logic [AW-1:0]         mem_rd_addr,
   input  vlmrd_pkg::data_type   mem_rd_data,
   output logic                  done_valid,
   input  logic                  done_ready,
   output vlmrd_pkg::result_type done_result
);
   import vlmrd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type       state_ff, state_in;
   op_type          op_ff, op_in;
   data_type        value_ff, value_in;
   data_type        new_value_ff, new_value_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic [CW-1:0]   rd_idx_ff, rd_idx_in;
   logic            cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [CW-1:0]   wp_ff, wp_in;
   logic [CW-1:0]   hits_ff, hits_in;
   logic            reject_ff, reject_in;

   logic accept;
   logic full;
   logic issue;
   logic hit;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign full      = (fill_ff == CW'(DEPTH));
   assign issue     = (state_ff == ST_WALK) && (rd_idx_ff != fill_ff);
   assign hit       = cmp_vld_ff && (mem_rd_data == value_ff);

   assign mem_rd_en   = issue;
   assign mem_rd_addr = rd_idx_ff[AW-1:0];

   assign done_valid              = (state_ff == ST_FINISH);
   assign done_result.match_count = CNT_W'(hits_ff);
   assign done_result.fill_count  = CNT_W'(fill_ff);
   assign done_result.full_reject = reject_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      new_value_in = new_value_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      wp_in        = wp_ff;
      hits_in      = hits_ff;
      reject_in    = reject_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = fill_ff[AW-1:0];
      mem_wr_data  = req.value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in        = req.op;
               value_in     = req.value;
               new_value_in = req.new_value;
               hits_in      = '0;
               rd_idx_in    = '0;
               wp_in        = '0;
               reject_in    = 1'b0;
               if (req.op == OP_APPEND) begin
                  // An append is a single write at the tail, or a refusal.
                  state_in = ST_FINISH;
                  if (full) begin
                     reject_in = 1'b1;
                  end else begin
                     mem_wr_en = 1'b1;
                     fill_in   = fill_ff + 1'b1;
                  end
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (issue) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff;
            end
            if (cmp_vld_ff) begin
               if (hit) begin
                  hits_in = hits_ff + 1'b1;
               end
               case (op_ff)
                  OP_REPLACE: begin
                     if (hit) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = cmp_idx_ff[AW-1:0];
                        mem_wr_data = new_value_ff;
                     end
                  end
                  OP_DELETE: begin
                     // Survivors are copied down to the write pointer, which
                     // never passes the entry being compared.
                     if (!hit) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = wp_ff[AW-1:0];
                        mem_wr_data = mem_rd_data;
                        wp_in       = wp_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (!issue && !cmp_vld_ff) begin
               state_in = ST_FINISH;
               if (op_ff == OP_DELETE) begin
                  fill_in = wp_ff;
               end
            end
         end
         ST_FINISH: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      op_ff        <= op_in;
      value_ff     <= value_in;
      new_value_ff <= new_value_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      wp_ff        <= wp_in;
      hits_ff      <= hits_in;
      reject_ff    <= reject_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count beyond capacity");

   a_wp_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && cmp_vld_ff |-> wp_ff <= cmp_idx_ff)
      else $error("delete write pointer ran ahead of the compare");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> rd_idx_ff <= fill_ff)
      else $error("read index beyond fill count");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item left no work in progress");

endmodule

// ===== design/value_list_match_replace_delete.sv =====
// Top level of the value list block: engine, entry storage and result register.
// Depends on vlmrd_pkg, vlmrd_if, vlmrd_mem and vlmrd_engine.
//
// The block keeps an ordered list of up to DEPTH signed 32-bit entries and a
// fill count. Each item on the req channel carries an op (append, replace,
// count, delete), a value and a replacement value; each item yields exactly
// one item on the rsp channel with the match count, the fill count after the
// operation and a flag for an append refused on a full list.
// An append's response passes from the sequencer's finish state into the
// output register. Replace, count and delete walk the stored entries through
// one comparator, one entry per cycle behind a registered memory read, and
// their response takes the same path. The single read port sets the pace of
// the walk.
// req.ready is high only while the sequencer is idle; one item is worked on
// at a time. A finished response sits in an output register, so the next item
// is accepted while the receiver stalls; the sequencer then holds its result
// until that register is free. Reset empties the list (fill count zero) and
// drops any pending response; entry contents are not cleared.
module value_list_match_replace_delete #(
   parameter int DEPTH = 16
) (
   input logic         clock,
   input logic         reset,
   vlmrd_req_if.sink   req,
   vlmrd_rsp_if.source rsp
);
   import vlmrd_pkg::*;

   // Address width for the entries and count width able to hold DEPTH itself.
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   data_type      mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   data_type      mem_rd_data;

   logic       done_valid;
   logic       done_ready;
   result_type done_result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   vlmrd_engine #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_result (done_result)
   );

   vlmrd_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The output register takes a new result when it is empty or being drained.
   assign done_ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_result;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.match_count = rsp_data_ff.match_count;
   assign rsp.fill_count  = rsp_data_ff.fill_count;
   assign rsp.full_reject = rsp_data_ff.full_reject;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for value_list_match_replace_delete: directed and random
// request items against a behavioral list predictor. Depends on vlmrd_pkg, vlmrd_if
// and the block's RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vlmrd_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_WAIT  = 50;
   localparam int RANDOM_ITEMS = 1100;

   // One request item plus the flow-control hints the driver acts on.
   typedef struct {
      op_type   op;
      data_type value;
      data_type new_value;
      bit       drain_first;   // hold this item back until every result is in
      bit       hold_rsp;      // once accepted, the receiver stalls for a long stretch
      bit       quiet;         // once accepted, neither side idles at random
   } list_item_type;

   logic clock;
   logic reset;

   vlmrd_req_if req_ch ();
   vlmrd_rsp_if rsp_ch ();

   value_list_match_replace_delete #(
      .DEPTH(LIST_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   list_item_type pending_items[$];
   result_type    expected_results[$];

   // Predictor state: the list contents and how many entries are valid.
   data_type    list_entries[LIST_DEPTH];
   int unsigned list_fill;

   // A small pool of values makes matches, repeated hits and deletes of
   // several entries common; the rest of the time values are fully random.
   data_type    value_pool[6] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0,
                                  -32'sh1, 32'sh1, 32'sh5a5a_5a5a};

   int          mismatches;
   int          cycle_count;
   int          hold_left;
   logic        start_hold;
   logic        quiet_run;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Applies one request to the predicted list and returns the response the
   // block should give. Matching is exact equality of all 32 bits.
   function automatic result_type predict_list_op(op_type op, data_type value,
                                                  data_type new_value);
      result_type  res;
      int unsigned hits;
      int unsigned kept;
      hits = 0;
      res.full_reject = 1'b0;
      case (op)
         OP_APPEND: begin
            // A full list refuses the append and stays as it was.
            if (list_fill >= LIST_DEPTH) begin
               res.full_reject = 1'b1;
            end else begin
               list_entries[list_fill] = value;
               list_fill++;
            end
         end
         OP_REPLACE: begin
            for (int i = 0; i < list_fill; i++) begin
               if (list_entries[i] == value) begin
                  list_entries[i] = new_value;
                  hits++;
               end
            end
         end
         OP_COUNT: begin
            for (int i = 0; i < list_fill; i++) begin
               if (list_entries[i] == value) hits++;
            end
         end
         default: begin
            // Delete compacts the survivors toward the front, in order.
            kept = 0;
            for (int i = 0; i < list_fill; i++) begin
               if (list_entries[i] == value) begin
                  hits++;
               end else begin
                  list_entries[kept] = list_entries[i];
                  kept++;
               end
            end
            list_fill = kept;
         end
      endcase
      res.match_count = cnt_type'(hits);
      res.fill_count  = cnt_type'(list_fill);
      return res;
   endfunction

   function automatic data_type pick_value();
      if ($urandom_range(99) < 70) return value_pool[$urandom_range(5)];
      return data_type'($urandom);
   endfunction

   function automatic void push_item(op_type op, data_type value, data_type new_value,
                                     bit drain_first = 1'b0, bit hold_rsp = 1'b0,
                                     bit quiet = 1'b0);
      list_item_type item;
      item.op          = op;
      item.value       = value;
      item.new_value   = new_value;
      item.drain_first = drain_first;
      item.hold_rsp    = hold_rsp;
      item.quiet       = quiet;
      pending_items.push_back(item);
   endfunction

   // Request driver. An item leaves the queue at the edge where it is
   // accepted, and its expected response is predicted right there, so the
   // predictor sees requests in exactly the order the block does. Valid is
   // assigned once per edge: it stays high across back-to-back items.
   always @(posedge clock) begin : request_driver
      bit            offer;
      bit            accepted;
      list_item_type head;
      accepted = req_ch.valid && req_ch.ready;
      if (reset) begin
         req_ch.valid <= 1'b0;
         start_hold   <= 1'b0;
      end else begin
         if (accepted) begin
            head = pending_items.pop_front();
            expected_results.push_back(predict_list_op(head.op, head.value,
                                                       head.new_value));
            quiet_run <= head.quiet;
         end
         start_hold <= accepted && head.hold_rsp;
         if (req_ch.valid && !accepted) begin
            // An offered item stays on the bus until it is taken.
            offer = 1'b1;
         end else begin
            offer = pending_items.size() != 0;
            if (offer) begin
               head = pending_items[0];
               if (head.drain_first && expected_results.size() != 0) begin
                  offer = 1'b0;
               end else if (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
                  offer = 1'b0;
               end
            end
         end
         req_ch.valid <= offer;
         if (offer) begin
            req_ch.op        <= pending_items[0].op;
            req_ch.value     <= pending_items[0].value;
            req_ch.new_value <= pending_items[0].new_value;
         end
      end
   end

   // Long receiver stall, counted on its own. While it runs, the block's
   // output register and its sequencer fill up and req.ready must drop.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (start_hold) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: every accepted response is checked field by field
   // against the oldest prediction.
   always @(posedge clock) begin : response_monitor
      result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: response with no request outstanding: ",
                            "match %0d fill %0d reject %0b"},
                           $realtime, rsp_ch.match_count, rsp_ch.fill_count,
                           rsp_ch.full_reject);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.match_count !== want.match_count ||
                   rsp_ch.fill_count !== want.fill_count ||
                   rsp_ch.full_reject !== want.full_reject) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: expected match %0d fill %0d reject %0b, ",
                               "got match %0d fill %0d reject %0b"},
                              $realtime, want.match_count, want.fill_count,
                              want.full_reject, rsp_ch.match_count, rsp_ch.fill_count,
                              rsp_ch.full_reject);
               end
            end
         end
         rsp_ch.ready <= (hold_left == 0) && (quiet_run || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int append_pct;
      int pick;
      op_type op;

      mismatches       = 0;
      cycle_count      = 0;
      list_fill        = 0;
      quiet_run        = 1'b0;
      start_hold       = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_APPEND;
      req_ch.value     = '0;
      req_ch.new_value = '0;
      rsp_ch.ready     = 1'b0;

      // Directed part. Match operations on an empty list come first.
      push_item(OP_COUNT,   32'sh0,          32'sh0);
      push_item(OP_REPLACE, -32'sh1,         32'sh7fff_ffff);
      push_item(OP_DELETE,  32'sh8000_0000,  32'sh0);
      // Fill the list to capacity with extremes and repeats; append ignores
      // new_value, so it carries random bits.
      for (int i = 0; i < LIST_DEPTH; i++)
         push_item(OP_APPEND, value_pool[i % 4], data_type'($urandom));
      // One more append must be refused on the full list.
      push_item(OP_APPEND, 32'sh1, 32'sh1);
      push_item(OP_COUNT,   32'sh8000_0000, 32'sh0);
      push_item(OP_REPLACE, 32'sh8000_0000, 32'sh7fff_ffff);
      push_item(OP_COUNT,   32'sh7fff_ffff, -32'sh1);
      // Delete several entries at once; order of the rest must be kept.
      push_item(OP_DELETE,  32'sh7fff_ffff, 32'sh0);
      push_item(OP_REPLACE, 32'sh1234_5678, 32'sh0);
      push_item(OP_DELETE,  -32'sh1,        32'sh0);
      push_item(OP_COUNT,   32'sh0,         32'sh0);

      // Random part, in blocks of 100 items with a varying mix so the list
      // spends time both near empty and at capacity.
      append_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) append_pct = $urandom_range(75, 25);
         pick = $urandom_range(99);
         if (pick < append_pct) begin
            op = OP_APPEND;
         end else begin
            case ($urandom_range(2))
               0: op = OP_REPLACE;
               1: op = OP_COUNT;
               default: op = OP_DELETE;
            endcase
         end
         // The sender drains the block before the first random item and a
         // few times later; one item starts the long receiver stall, and one
         // stretch runs with no random idling on either side.
         push_item(op, pick_value(), pick_value(),
                   n == 0 || n == 600 || n == 900,
                   n == 300,
                   n >= 700 && n < 850);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      // A stray response after the last expected one still counts.
      repeat (SETTLE_WAIT) @(posedge clock);

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
